>>> rtl/hga_pkg.sv
// Shared types and constants of the generational handle allocator.
package hga_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int GEN_BITS  = 16;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;

  localparam logic [1:0] ACT_CREATE  = 2'd0;
  localparam logic [1:0] ACT_DESTROY = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_STALE = 2'd2;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [GEN_BITS-1:0] gen_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // Per-slot record: occupied flag and current generation.
  typedef struct packed {
    logic live;
    gen_t gen;
  } slot_entry_t;

  // Free stack record: the slot carries the generation it will be reissued with.
  typedef struct packed {
    idx_t idx;
    gen_t gen;
  } stack_entry_t;

endpackage

>>> rtl/hga_req_if.sv
// Request channel of the generational handle allocator.
interface hga_req_if import hga_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] action;
  idx_t       handle_index;
  gen_t       handle_generation;

  modport source (output valid, action, handle_index, handle_generation, input ready);
  modport sink (input valid, action, handle_index, handle_generation, output ready);
endinterface

>>> rtl/hga_rsp_if.sv
// Response channel of the generational handle allocator.
interface hga_rsp_if import hga_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  idx_t       new_index;
  gen_t       new_generation;
  logic       is_live;
  cnt_t       live_count;

  modport source (output valid, status, new_index, new_generation, is_live, live_count,
                  input ready);
  modport sink (input valid, status, new_index, new_generation, is_live, live_count,
                output ready);
endinterface

>>> rtl/hga_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/generational_handle_allocator.sv
// Top level of the generational handle allocator.
//
// Each request transaction (create, destroy or query) is handled in order: first
// the slot table and the free stack are read, then the result is formed and the
// slot table and stack are written back. The next request is taken only after
// that write-back, since the read data of the two memories is registered, so a
// new request is never accepted while an earlier one is in flight, and the
// write-back waits while the response side still holds an earlier result. Slot
// records at or above the high-water mark are never taken as live, so no clearing
// pass is needed after reset. Action code 3 behaves as a query.
module generational_handle_allocator import hga_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  hga_req_if.sink      req,
  hga_rsp_if.source    rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic state;
  logic accept;
  logic out_free;
  logic commit;

  logic [1:0] action_q;
  idx_t       idx_q;
  gen_t       gen_q;

  cnt_t free_depth, free_depth_next;
  cnt_t high_water, high_water_next;
  cnt_t live_total, live_total_next;

  logic        out_valid;
  logic [1:0]  out_status, out_status_next;
  idx_t        out_index, out_index_next;
  gen_t        out_gen, out_gen_next;
  logic        out_live, out_live_next;

  slot_entry_t  slot_rd, slot_wr;
  stack_entry_t stack_rd, stack_wr;
  logic         slot_we, stack_we;
  idx_t         slot_waddr, stack_waddr;
  logic         hit;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign commit   = (state == ST_LOOK) && out_free;

  assign req.ready = (state == ST_IDLE);

  hga_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wr),
    .re    (accept),
    .raddr (req.handle_index),
    .rdata (slot_rd)
  );

  hga_ram #(
    .WIDTH ($bits(stack_entry_t)),
    .DEPTH (MAX_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wr),
    .re    (accept),
    .raddr (IDX_W'(free_depth - 1'b1)),
    .rdata (stack_rd)
  );

  // A handle is live when its slot has been handed out, is occupied and the
  // generations agree.
  assign hit = ({1'b0, idx_q} < high_water) && slot_rd.live && (slot_rd.gen == gen_q);

  always_comb begin
    free_depth_next = free_depth;
    high_water_next = high_water;
    live_total_next = live_total;
    out_status_next = STATUS_DONE;
    out_index_next  = '0;
    out_gen_next    = '0;
    out_live_next   = 1'b0;
    slot_we         = 1'b0;
    slot_waddr      = idx_q;
    slot_wr         = '{live: 1'b0, gen: GEN_BITS'(slot_rd.gen + 1'b1)};
    stack_we        = 1'b0;
    stack_waddr     = IDX_W'(free_depth);
    stack_wr        = '{idx: idx_q, gen: GEN_BITS'(slot_rd.gen + 1'b1)};
    case (action_q)
      ACT_CREATE: begin
        if (free_depth != '0) begin
          free_depth_next = free_depth - 1'b1;
          live_total_next = live_total + 1'b1;
          out_index_next  = stack_rd.idx;
          out_gen_next    = stack_rd.gen;
          slot_we         = commit;
          slot_waddr      = stack_rd.idx;
          slot_wr         = '{live: 1'b1, gen: stack_rd.gen};
        end else if (high_water < CNT_W'(MAX_SLOTS)) begin
          high_water_next = high_water + 1'b1;
          live_total_next = live_total + 1'b1;
          out_index_next  = IDX_W'(high_water);
          slot_we         = commit;
          slot_waddr      = IDX_W'(high_water);
          slot_wr         = '{live: 1'b1, gen: '0};
        end else begin
          out_status_next = STATUS_FULL;
        end
      end
      ACT_DESTROY: begin
        if (hit) begin
          out_live_next = 1'b1;
          slot_we       = commit;
          if (free_depth < CNT_W'(MAX_SLOTS)) begin
            stack_we        = commit;
            free_depth_next = free_depth + 1'b1;
          end
          if (live_total != '0) begin
            live_total_next = live_total - 1'b1;
          end
        end else begin
          out_status_next = STATUS_STALE;
        end
      end
      default: begin
        if (hit) begin
          out_live_next = 1'b1;
        end else begin
          out_status_next = STATUS_STALE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      free_depth <= '0;
      high_water <= '0;
      live_total <= '0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (commit) begin
            state      <= ST_IDLE;
            free_depth <= free_depth_next;
            high_water <= high_water_next;
            live_total <= live_total_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_q <= req.action;
      idx_q    <= req.handle_index;
      gen_q    <= req.handle_generation;
    end
    if (commit) begin
      out_status <= out_status_next;
      out_index  <= out_index_next;
      out_gen    <= out_gen_next;
      out_live   <= out_live_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.new_index      = out_index;
  assign rsp.new_generation = out_gen;
  assign rsp.is_live        = out_live;
  assign rsp.live_count     = live_total;

endmodule
